// ===== design/mlkem_ntt_pkg.sv =====
package mlkem_ntt_pkg;

    localparam int NumCoeffs = 256;
    localparam int IdxW      = 8;
    localparam int CoefW     = 16;
    localparam int OutW      = 12;
    localparam int ModQ      = 3329;
    localparam int ZetaW     = 7;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_NTT   = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_RD_A,
        ST_RD_B,
        ST_MUL,
        ST_MONT,
        ST_TW,
        ST_WA,
        ST_WB,
        ST_FIN_RD,
        ST_FIN_RED,
        ST_FIN_WB
    } t_state;

    function automatic logic signed [15:0] zeta(input logic [6:0] k);
        logic signed [15:0] z;
        case (k)
            7'd0: z = -16'sd1044;   7'd1: z = -16'sd758;    7'd2: z = -16'sd359;
            7'd3: z = -16'sd1517;   7'd4: z = 16'sd1493;    7'd5: z = 16'sd1422;
            7'd6: z = 16'sd287;     7'd7: z = 16'sd202;     7'd8: z = -16'sd171;
            7'd9: z = 16'sd622;     7'd10: z = 16'sd1577;   7'd11: z = 16'sd182;
            7'd12: z = 16'sd962;    7'd13: z = -16'sd1202;  7'd14: z = -16'sd1474;
            7'd15: z = 16'sd1468;   7'd16: z = 16'sd573;    7'd17: z = -16'sd1325;
            7'd18: z = 16'sd264;    7'd19: z = 16'sd383;    7'd20: z = -16'sd829;
            7'd21: z = 16'sd1458;   7'd22: z = -16'sd1602;  7'd23: z = -16'sd130;
            7'd24: z = -16'sd681;   7'd25: z = 16'sd1017;   7'd26: z = 16'sd732;
            7'd27: z = 16'sd608;    7'd28: z = -16'sd1542;  7'd29: z = 16'sd411;
            7'd30: z = -16'sd205;   7'd31: z = -16'sd1571;  7'd32: z = 16'sd1223;
            7'd33: z = 16'sd652;    7'd34: z = -16'sd552;   7'd35: z = 16'sd1015;
            7'd36: z = -16'sd1293;  7'd37: z = 16'sd1491;   7'd38: z = -16'sd282;
            7'd39: z = -16'sd1544;  7'd40: z = 16'sd516;    7'd41: z = -16'sd8;
            7'd42: z = -16'sd320;   7'd43: z = -16'sd666;   7'd44: z = -16'sd1618;
            7'd45: z = -16'sd1162;  7'd46: z = 16'sd126;    7'd47: z = 16'sd1469;
            7'd48: z = -16'sd853;   7'd49: z = -16'sd90;    7'd50: z = -16'sd271;
            7'd51: z = 16'sd830;    7'd52: z = 16'sd107;    7'd53: z = -16'sd1421;
            7'd54: z = -16'sd247;   7'd55: z = -16'sd951;   7'd56: z = -16'sd398;
            7'd57: z = 16'sd961;    7'd58: z = -16'sd1508;  7'd59: z = -16'sd725;
            7'd60: z = 16'sd448;    7'd61: z = -16'sd1065;  7'd62: z = 16'sd677;
            7'd63: z = -16'sd1275;  7'd64: z = -16'sd1103;  7'd65: z = 16'sd430;
            7'd66: z = 16'sd555;    7'd67: z = 16'sd843;    7'd68: z = -16'sd1251;
            7'd69: z = 16'sd871;    7'd70: z = 16'sd1550;   7'd71: z = 16'sd105;
            7'd72: z = 16'sd422;    7'd73: z = 16'sd587;    7'd74: z = 16'sd177;
            7'd75: z = -16'sd235;   7'd76: z = -16'sd291;   7'd77: z = -16'sd460;
            7'd78: z = 16'sd1574;   7'd79: z = 16'sd1653;   7'd80: z = -16'sd246;
            7'd81: z = 16'sd778;    7'd82: z = 16'sd1159;   7'd83: z = -16'sd147;
            7'd84: z = -16'sd777;   7'd85: z = 16'sd1483;   7'd86: z = -16'sd602;
            7'd87: z = 16'sd1119;   7'd88: z = -16'sd1590;  7'd89: z = 16'sd644;
            7'd90: z = -16'sd872;   7'd91: z = 16'sd349;    7'd92: z = 16'sd418;
            7'd93: z = 16'sd329;    7'd94: z = -16'sd156;   7'd95: z = -16'sd75;
            7'd96: z = 16'sd817;    7'd97: z = 16'sd1097;   7'd98: z = 16'sd603;
            7'd99: z = 16'sd610;    7'd100: z = 16'sd1322;  7'd101: z = -16'sd1285;
            7'd102: z = -16'sd1465; 7'd103: z = 16'sd384;   7'd104: z = -16'sd1215;
            7'd105: z = -16'sd136;  7'd106: z = 16'sd1218;  7'd107: z = -16'sd1335;
            7'd108: z = -16'sd874;  7'd109: z = 16'sd220;   7'd110: z = -16'sd1187;
            7'd111: z = -16'sd1659; 7'd112: z = -16'sd1185; 7'd113: z = -16'sd1530;
            7'd114: z = -16'sd1278; 7'd115: z = 16'sd794;   7'd116: z = -16'sd1510;
            7'd117: z = -16'sd854;  7'd118: z = -16'sd870;  7'd119: z = 16'sd478;
            7'd120: z = -16'sd108;  7'd121: z = -16'sd308;  7'd122: z = 16'sd996;
            7'd123: z = 16'sd991;   7'd124: z = 16'sd958;   7'd125: z = -16'sd1460;
            7'd126: z = 16'sd1522;  default: z = 16'sd1628;
        endcase
        return z;
    endfunction

endpackage

// ===== design/mlkem_ntt_bfly.sv =====
// Butterfly datapath: three register stages (product, Montgomery factor,
// reduced twiddle product), then add and subtract against the held a.
module mlkem_ntt_bfly (
    input  logic                               i_clk,
    input  logic signed [mlkem_ntt_pkg::CoefW-1:0] i_a,
    input  logic signed [mlkem_ntt_pkg::CoefW-1:0] i_b,
    input  logic signed [mlkem_ntt_pkg::CoefW-1:0] i_zeta,
    output logic signed [mlkem_ntt_pkg::CoefW-1:0] o_a,
    output logic signed [mlkem_ntt_pkg::CoefW-1:0] o_b
);
    logic signed [31:0] r_p;
    logic signed [31:0] r_p2;
    logic signed [15:0] r_m;
    logic signed [15:0] r_t;

    always_ff @(posedge i_clk) begin
        r_p  <= 32'(i_b) * 32'(i_zeta);
        // m = low16(p * qinv); -3327 mod 2^16 = 62209
        r_m  <= 16'(r_p[15:0] * 16'd62209);
        r_p2 <= r_p;
        // exact division: p - m*q has zero low half
        r_t  <= 16'((r_p2 - 32'(r_m) * 32'sd3329) >>> 16);
    end

    always_comb begin
        o_a = i_a + r_t;
        o_b = i_a - r_t;
    end
endmodule

// ===== design/mlkem_ntt_reduce.sv =====
// Barrett reduction with conditional add of q; quotient registered, then
// subtract and correct.
module mlkem_ntt_reduce (
    input  logic                                   i_clk,
    input  logic signed [mlkem_ntt_pkg::CoefW-1:0] i_x,
    output logic        [mlkem_ntt_pkg::OutW-1:0]  o_r
);
    logic signed [15:0] r_x;
    logic signed [15:0] r_s;
    logic signed [31:0] r;

    always_ff @(posedge i_clk) begin
        r_x <= i_x;
        r_s <= 16'((32'(i_x) * 32'sd20159 + 32'sd33554432) >>> 26);
    end

    always_comb begin
        r = 32'(r_x) - 32'(r_s) * 32'sd3329;
        if (r < 0) begin
            r = r + 32'sd3329;
        end
        o_r = r[11:0];
    end
endmodule

// ===== design/mlkem_forward_ntt.sv =====
// Forward ML-KEM NTT engine, n = 256, q = 3329, on one coefficient RAM.
// Input channel: i_valid / o_stall carrying i_opcode, i_coeff_index and
// i_coeff_in. Output channel: o_valid / i_stall carrying o_coeff_out and
// o_done_res; exactly one result word per accepted input word.
// One word is in flight at a time: o_stall is high while an operation runs
// and while its result waits in the output register.
// Write and unused opcode set the output register on acceptance; a read
// first passes through one RAM read. The transform runs 896 butterflies
// (read a, read b, three multiply stages, write a, write b), then a final
// Barrett sweep (read, reduce, write back) over all 256 coefficients.
// The next word is taken in the cycle after the result is accepted.
// A stalled result holds its value; no new word is taken meanwhile.
// Reset clears the controller and the output register only; coefficients
// are undefined until written.
module mlkem_forward_ntt #(
    parameter int NUM_COEFFS = mlkem_ntt_pkg::NumCoeffs
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_coeff_index,
    input  logic [11:0] i_coeff_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [11:0] o_coeff_out,
    output logic        o_done_res
);
    localparam int IW = $clog2(NUM_COEFFS);

    logic signed [15:0] mem [NUM_COEFFS];

    mlkem_ntt_pkg::t_state r_state, n_state;
    logic [IW-2:0] r_j, n_j;        // butterfly counter within layer
    logic [2:0]    r_lay, n_lay;    // 0 => len = NUM_COEFFS / 2
    logic [IW-1:0] r_idx, n_idx;    // final reduction sweep
    logic signed [15:0] r_a, n_a;
    logic signed [15:0] r_b, n_b;
    logic [11:0]   r_out, n_out;
    logic          r_done, n_done;
    logic          r_ov, n_ov;

    logic signed [15:0] r_rd;
    logic signed [15:0] bf_a, bf_b;
    logic [11:0]   red;

    logic          we;
    logic [IW-1:0] waddr, raddr;
    logic signed [15:0] wdata;

    logic          acc;
    logic [2:0]    sh;
    logic [IW-1:0] lenv, grp, off, ia, ib;
    logic [IW-2:0] k;
    logic signed [15:0] z;

    assign acc     = i_valid && !o_stall;
    assign o_stall = r_ov || (r_state != mlkem_ntt_pkg::ST_IDLE);

    // len = N/2 >> lay; group = j / len; a index = group * 2len + j mod len
    always_comb begin
        sh   = 3'(IW - 1) - r_lay;
        lenv = IW'(NUM_COEFFS / 2) >> r_lay;
        grp  = {1'b0, r_j} >> sh;
        off  = {1'b0, r_j} & (lenv - 1'b1);
        ia   = ((grp << 1) << sh) | off;
        ib   = ia | lenv;
        k    = (IW-1)'((IW'(1) << r_lay) + grp);
    end
    assign z = mlkem_ntt_pkg::zeta(k);

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rd <= mem[raddr];
    end

    mlkem_ntt_bfly u_bfly (
        .i_clk  (i_clk),
        .i_a    (r_a),
        .i_b    (r_rd),
        .i_zeta (z),
        .o_a    (bf_a),
        .o_b    (bf_b)
    );
    mlkem_ntt_reduce u_red (.i_clk(i_clk), .i_x(r_rd), .o_r(red));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mlkem_ntt_pkg::ST_IDLE;
            r_ov    <= 1'b0;
            r_lay   <= '0;
            r_j     <= '0;
            r_idx   <= '0;
            r_a     <= '0;
            r_b     <= '0;
            r_out   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_lay   <= n_lay;
            r_j     <= n_j;
            r_idx   <= n_idx;
            r_a     <= n_a;
            r_b     <= n_b;
            r_out   <= n_out;
            r_done  <= n_done;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ov    = r_ov;
        n_lay   = r_lay;
        n_j     = r_j;
        n_idx   = r_idx;
        n_a     = r_a;
        n_b     = r_b;
        n_out   = r_out;
        n_done  = r_done;
        we      = 1'b0;
        waddr   = ia;
        wdata   = bf_a;
        raddr   = ia;
        if (r_ov && !i_stall) begin
            n_ov = 1'b0;
        end
        case (r_state)
            mlkem_ntt_pkg::ST_IDLE: begin
                if (acc) begin
                    n_out  = '0;
                    n_done = 1'b1;
                    case (mlkem_ntt_pkg::t_op'(i_opcode))
                        mlkem_ntt_pkg::OP_WRITE: begin
                            we    = 1'b1;
                            waddr = IW'(i_coeff_index);
                            wdata = {4'd0, i_coeff_in};
                            n_ov  = 1'b1;
                        end
                        mlkem_ntt_pkg::OP_NTT: begin
                            n_lay   = '0;
                            n_j     = '0;
                            n_state = mlkem_ntt_pkg::ST_RD_A;
                        end
                        mlkem_ntt_pkg::OP_READ: begin
                            raddr   = IW'(i_coeff_index);
                            n_state = mlkem_ntt_pkg::ST_READ;
                        end
                        default: begin
                            n_done = 1'b0;
                            n_ov   = 1'b1;
                        end
                    endcase
                end
            end
            mlkem_ntt_pkg::ST_READ: begin
                n_out   = r_rd[11:0];
                n_ov    = 1'b1;
                n_state = mlkem_ntt_pkg::ST_IDLE;
            end
            mlkem_ntt_pkg::ST_RD_A: begin
                n_state = mlkem_ntt_pkg::ST_RD_B;
            end
            mlkem_ntt_pkg::ST_RD_B: begin
                // r_rd holds a; fetch b
                raddr   = ib;
                n_a     = r_rd;
                n_state = mlkem_ntt_pkg::ST_MUL;
            end
            mlkem_ntt_pkg::ST_MUL: begin
                n_state = mlkem_ntt_pkg::ST_MONT;
            end
            mlkem_ntt_pkg::ST_MONT: begin
                n_state = mlkem_ntt_pkg::ST_TW;
            end
            mlkem_ntt_pkg::ST_TW: begin
                n_state = mlkem_ntt_pkg::ST_WA;
            end
            mlkem_ntt_pkg::ST_WA: begin
                we      = 1'b1;
                waddr   = ia;
                wdata   = bf_a;
                n_b     = bf_b;
                n_state = mlkem_ntt_pkg::ST_WB;
            end
            mlkem_ntt_pkg::ST_WB: begin
                we    = 1'b1;
                waddr = ib;
                wdata = r_b;
                if (r_j == '1) begin
                    n_j = '0;
                    if (r_lay == 3'(IW - 2)) begin
                        n_idx   = '0;
                        n_state = mlkem_ntt_pkg::ST_FIN_RD;
                    end else begin
                        n_lay   = r_lay + 3'd1;
                        n_state = mlkem_ntt_pkg::ST_RD_A;
                    end
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = mlkem_ntt_pkg::ST_RD_A;
                end
            end
            mlkem_ntt_pkg::ST_FIN_RD: begin
                raddr   = r_idx;
                n_state = mlkem_ntt_pkg::ST_FIN_RED;
            end
            mlkem_ntt_pkg::ST_FIN_RED: begin
                n_state = mlkem_ntt_pkg::ST_FIN_WB;
            end
            mlkem_ntt_pkg::ST_FIN_WB: begin
                we    = 1'b1;
                waddr = r_idx;
                wdata = {4'd0, red};
                n_idx = r_idx + 1'b1;
                if (r_idx == '1) begin
                    n_ov    = 1'b1;
                    n_state = mlkem_ntt_pkg::ST_IDLE;
                end else begin
                    n_state = mlkem_ntt_pkg::ST_FIN_RD;
                end
            end
            default: begin
                n_state = mlkem_ntt_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_valid     = r_ov;
    assign o_coeff_out = r_out;
    assign o_done_res  = r_done;

`ifndef ASSERT_OFF
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != mlkem_ntt_pkg::ST_IDLE |-> o_stall) else $error("busy without stall");
    a_result_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("input open while a result waits");
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_coeff_out) && $stable(o_done_res))
        else $error("stalled result changed");
    a_lay_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lay <= 3'(IW - 2)) else $error("layer overflow");
`endif
endmodule
